[hw/rtl/sadf_pkg.sv]
// ----------------------------------------------------------------------------
// sadf_pkg: shared constants and types
// Sizes, register indexes and the result frame layout of the sensor framer.
// ----------------------------------------------------------------------------
package sadf_pkg;

   localparam int RING_DEPTH  = 8;
   localparam int SAMPLE_BITS = 12;
   localparam int PTR_BITS    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int SUM_BITS    = SAMPLE_BITS + PTR_BITS;
   // frame carries sum bits 14..4; narrower sums are zero extended
   localparam int SUM_EXT_BITS = (SUM_BITS > 15) ? SUM_BITS : 15;

   localparam int PIN_COUNT = 3;
   localparam int CNT_BITS  = 4;
   localparam int ADDR_BITS = 3;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 4;

   localparam logic [CNT_BITS-1:0]  LIMIT_RESET   = 4'd10;
   localparam logic [ADDR_BITS-1:0] ADDRESS_RESET = 3'd0;
   localparam logic                 START_BIT     = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODULE_ADDRESS = 2'd0,
      CSR_DEBOUNCE_LIMIT = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] frame_byte0;
      logic [6:0] frame_byte1;
      logic [6:0] frame_byte2;
      logic [6:0] frame_byte3;
   } frame_type;

   typedef struct packed {
      logic                load;
      logic [PTR_BITS-1:0] slot;
   } ring_ctrl_type;

endpackage

[hw/rtl/sadf_if.sv]
// ----------------------------------------------------------------------------
// sadf_req_if / sadf_rsp_if: request and result channels
// Valid/ready channels carrying the sample tick and the output frame.
// ----------------------------------------------------------------------------
interface sadf_req_if;
   logic                              valid;
   logic                              ready;
   logic [sadf_pkg::SAMPLE_BITS-1:0]  sample_ch1;
   logic [sadf_pkg::SAMPLE_BITS-1:0]  sample_ch2;
   logic                              pin0_level;
   logic                              pin1_level;
   logic                              pin2_level;

   modport source (output valid, sample_ch1, sample_ch2, pin0_level, pin1_level,
                   pin2_level, input ready);
   modport sink (input valid, sample_ch1, sample_ch2, pin0_level, pin1_level,
                 pin2_level, output ready);
endinterface

interface sadf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte0;
   logic [6:0] frame_byte1;
   logic [6:0] frame_byte2;
   logic [6:0] frame_byte3;

   modport source (output valid, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
                   input ready);
   modport sink (input valid, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
                 output ready);
endinterface

[hw/rtl/sensor_average_debounce_framer_core.sv]
// ----------------------------------------------------------------------------
// sensor_average_debounce_framer_core: sensor tick to 4-byte frame
// Eight-sample moving sums of two channels, three debounced pins, one frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one request per converter tick: two 12-bit samples and
//   three raw pin levels. rsp_bus returns one frame per request: a start bit,
//   the module address, bits 14..4 of both moving sums and the qualified pins.
//   csr_we/csr_index/csr_wdata write the address (index 0) and the debounce
//   limit (index 1); other indexes are ignored. Write only while idle.
//   Each frame is queued as its request is accepted. Throughput: one request
//   per cycle while the queue has room; ring, sums and counters update in
//   the accepting cycle, so the next request sees them at once.
//   A two-entry frame queue sits on the output: a request is still taken
//   while one frame waits, and req ready drops only when both entries hold
//   frames the receiver has not taken.
//   Reset (synchronous, active high) clears rings, sums, pointer, counters,
//   qualified bits and the queue, sets address 0 and debounce limit 10.
// ----------------------------------------------------------------------------
module sensor_average_debounce_framer_core (
   input  logic                                clock,
   input  logic                                reset,
   sadf_req_if.sink                            req_bus,
   sadf_rsp_if.source                          rsp_bus,
   input  logic                                csr_we,
   input  logic [sadf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sadf_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [sadf_pkg::ADDR_BITS-1:0] address_ff;
   logic [sadf_pkg::CNT_BITS-1:0]  limit_ff;
   logic [sadf_pkg::PTR_BITS-1:0]  ptr_ff;
   logic [sadf_pkg::PTR_BITS-1:0]  ptr_in;

   logic                           accept;
   logic                           pop;
   sadf_pkg::ring_ctrl_type        ring_ctrl;
   logic [sadf_pkg::SUM_BITS-1:0]  sum1_next;
   logic [sadf_pkg::SUM_BITS-1:0]  sum2_next;
   logic [sadf_pkg::SUM_EXT_BITS-1:0] sum1_ext;
   logic [sadf_pkg::SUM_EXT_BITS-1:0] sum2_ext;
   logic [sadf_pkg::PIN_COUNT-1:0] levels;
   logic [sadf_pkg::PIN_COUNT-1:0] qual_next;
   sadf_pkg::frame_type            frame_new;

   sadf_pkg::frame_type            head_ff;
   sadf_pkg::frame_type            tail_ff;
   logic [1:0]                     count_ff;

   // ---- config registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff <= sadf_pkg::ADDRESS_RESET;
         limit_ff   <= sadf_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            sadf_pkg::CSR_MODULE_ADDRESS: address_ff <= csr_wdata[sadf_pkg::ADDR_BITS-1:0];
            sadf_pkg::CSR_DEBOUNCE_LIMIT: limit_ff   <= csr_wdata[sadf_pkg::CNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign req_bus.ready = (count_ff != 2'd2);
   assign accept        = req_bus.valid && req_bus.ready;
   assign pop           = rsp_bus.valid && rsp_bus.ready;

   // ---- shared ring pointer ----
   always_comb begin
      if (ptr_ff == sadf_pkg::PTR_BITS'(sadf_pkg::RING_DEPTH - 1)) begin
         ptr_in = '0;
      end else begin
         ptr_in = ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else if (accept) begin
         ptr_ff <= ptr_in;
      end
   end

   assign ring_ctrl.load = accept;
   assign ring_ctrl.slot = ptr_ff;

   sadf_chan_avg u_avg_ch1 (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ring_ctrl),
      .sample   (req_bus.sample_ch1),
      .sum_next (sum1_next)
   );

   sadf_chan_avg u_avg_ch2 (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ring_ctrl),
      .sample   (req_bus.sample_ch2),
      .sum_next (sum2_next)
   );

   assign levels = {req_bus.pin2_level, req_bus.pin1_level, req_bus.pin0_level};

   sadf_debounce u_debounce (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .levels    (levels),
      .limit     (limit_ff),
      .qual_next (qual_next)
   );

   // ---- frame assembly from post-update state ----
   always_comb begin
      sum1_ext              = sadf_pkg::SUM_EXT_BITS'(sum1_next);
      sum2_ext              = sadf_pkg::SUM_EXT_BITS'(sum2_next);
      frame_new.frame_byte0 = {sadf_pkg::START_BIT, address_ff, sum1_ext[14:11]};
      frame_new.frame_byte1 = sum1_ext[10:4];
      frame_new.frame_byte2 = {qual_next, sum2_ext[14:11]};
      frame_new.frame_byte3 = sum2_ext[10:4];
   end

   // ---- two-entry output queue ----
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_ff + {1'b0, accept} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (accept && count_ff == 2'd1) begin
            head_ff <= frame_new;
         end else begin
            head_ff <= tail_ff;
         end
         if (accept && count_ff == 2'd2) begin
            tail_ff <= frame_new;
         end
      end else if (accept) begin
         if (count_ff == 2'd0) begin
            head_ff <= frame_new;
         end else begin
            tail_ff <= frame_new;
         end
      end
   end

   assign rsp_bus.valid       = (count_ff != 2'd0);
   assign rsp_bus.frame_byte0 = head_ff.frame_byte0;
   assign rsp_bus.frame_byte1 = head_ff.frame_byte1;
   assign rsp_bus.frame_byte2 = head_ff.frame_byte2;
   assign rsp_bus.frame_byte3 = head_ff.frame_byte3;

   // ---- assertions ----
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> count_ff == $past(count_ff) + {1'b0, $past(accept)} - {1'b0, $past(pop)})
      else $error("frame queue count out of step with requests and frames");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_bus.valid)
      else $error("request stalled with no frame waiting");

   a_ptr_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && ptr_ff == sadf_pkg::PTR_BITS'(sadf_pkg::RING_DEPTH - 1) |=> ptr_ff == '0)
      else $error("ring pointer did not wrap");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> count_ff == 2'd0 && ptr_ff == '0)
      else $error("queue or pointer not cleared by reset");

endmodule

[hw/rtl/sadf_chan_avg.sv]
// ----------------------------------------------------------------------------
// sadf_chan_avg: one channel of the moving sum
// Sample ring and running sum; replaces the slot chosen by the pointer.
// ----------------------------------------------------------------------------
module sadf_chan_avg (
   input  logic                             clock,
   input  logic                             reset,
   input  sadf_pkg::ring_ctrl_type          ctrl,
   input  logic [sadf_pkg::SAMPLE_BITS-1:0] sample,
   output logic [sadf_pkg::SUM_BITS-1:0]    sum_next
);

   logic [sadf_pkg::SAMPLE_BITS-1:0] ring_ff [sadf_pkg::RING_DEPTH];
   logic [sadf_pkg::SUM_BITS-1:0]    sum_ff;
   logic [sadf_pkg::SUM_BITS-1:0]    sum_in;
   logic [sadf_pkg::SAMPLE_BITS-1:0] oldest;

   always_comb begin
      oldest = ring_ff[ctrl.slot];
      // sum stays exact: old sample is always part of it
      sum_in = sum_ff - sadf_pkg::SUM_BITS'(oldest) + sadf_pkg::SUM_BITS'(sample);
   end

   assign sum_next = sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         for (int i = 0; i < sadf_pkg::RING_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (ctrl.load) begin
         sum_ff            <= sum_in;
         ring_ff[ctrl.slot] <= sample;
      end
   end

endmodule

[hw/rtl/sadf_debounce.sv]
// ----------------------------------------------------------------------------
// sadf_debounce: integrating debouncers
// One saturating counter per pin; qualified level flips only at the rails.
// ----------------------------------------------------------------------------
module sadf_debounce (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  logic [sadf_pkg::PIN_COUNT-1:0]    levels,
   input  logic [sadf_pkg::CNT_BITS-1:0]     limit,
   output logic [sadf_pkg::PIN_COUNT-1:0]    qual_next
);

   logic [sadf_pkg::CNT_BITS-1:0]  cnt_ff [sadf_pkg::PIN_COUNT];
   logic [sadf_pkg::CNT_BITS-1:0]  cnt_in [sadf_pkg::PIN_COUNT];
   logic [sadf_pkg::PIN_COUNT-1:0] qual_ff;
   logic [sadf_pkg::PIN_COUNT-1:0] qual_in;

   always_comb begin
      qual_in = qual_ff;
      for (int p = 0; p < sadf_pkg::PIN_COUNT; p++) begin
         cnt_in[p] = cnt_ff[p];
         if (levels[p]) begin
            if (cnt_ff[p] < limit) begin
               cnt_in[p] = cnt_ff[p] + 1'b1;
            end else begin
               qual_in[p] = 1'b1;
            end
         end else begin
            if (cnt_ff[p] != '0) begin
               cnt_in[p] = cnt_ff[p] - 1'b1;
            end else begin
               qual_in[p] = 1'b0;
            end
         end
      end
   end

   assign qual_next = qual_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         qual_ff <= '0;
         for (int p = 0; p < sadf_pkg::PIN_COUNT; p++) begin
            cnt_ff[p] <= '0;
         end
      end else if (load) begin
         qual_ff <= qual_in;
         for (int p = 0; p < sadf_pkg::PIN_COUNT; p++) begin
            cnt_ff[p] <= cnt_in[p];
         end
      end
   end

endmodule

[tb/sensor_average_debounce_framer_core_test.sv]
// ----------------------------------------------------------------------------
// sensor_average_debounce_framer_core_test: self-checking framer bench
// Sends sample ticks through the framer with random valid and ready gaps.
// An in-bench model of the moving sums, the pin debouncers and the frame
// packing predicts every frame. It runs over several address and debounce
// limit settings.
// ----------------------------------------------------------------------------
module sensor_average_debounce_framer_core_test;
   import sadf_pkg::*;

   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_REQUESTS = 125;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int REPORT_LIMIT   = 10;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX  = 2'd3;

   // Expected frames, predicted from the moving sums and the debouncers.
   class frame_scoreboard;
      logic [SAMPLE_BITS-1:0]  ring_ch1 [RING_DEPTH];
      logic [SAMPLE_BITS-1:0]  ring_ch2 [RING_DEPTH];
      logic [SUM_EXT_BITS-1:0] sum_ch1;
      logic [SUM_EXT_BITS-1:0] sum_ch2;
      logic [PTR_BITS-1:0]     slot;
      logic [CNT_BITS-1:0]     pin_count [PIN_COUNT];
      logic [PIN_COUNT-1:0]    qualified;
      logic [ADDR_BITS-1:0]    address;
      logic [CNT_BITS-1:0]     limit;
      frame_type               expected_frames [$];
      int                      frames_checked;
      int                      mismatches;

      function new();
         foreach (ring_ch1[i]) begin
            ring_ch1[i] = '0;
            ring_ch2[i] = '0;
         end
         foreach (pin_count[i]) pin_count[i] = '0;
         sum_ch1        = '0;
         sum_ch2        = '0;
         slot           = '0;
         qualified      = '0;
         address        = ADDRESS_RESET;
         limit          = LIMIT_RESET;
         frames_checked = 0;
         mismatches     = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [CSR_DATA_BITS-1:0] data);
         if (index == CSR_MODULE_ADDRESS) begin
            address = data[ADDR_BITS-1:0];
         end else if (index == CSR_DEBOUNCE_LIMIT) begin
            limit = data[CNT_BITS-1:0];
         end
      endfunction

      function void note_request(logic [SAMPLE_BITS-1:0] s1, logic [SAMPLE_BITS-1:0] s2,
                                 logic [PIN_COUNT-1:0] pins);
         frame_type f;
         sum_ch1 = sum_ch1 - ring_ch1[slot] + s1;
         sum_ch2 = sum_ch2 - ring_ch2[slot] + s2;
         ring_ch1[slot] = s1;
         ring_ch2[slot] = s2;
         slot = (slot == RING_DEPTH - 1) ? '0 : slot + 1'b1;
         for (int p = 0; p < PIN_COUNT; p++) begin
            // integrating debouncer: qualified bit moves only at the rails
            if (pins[p]) begin
               if (pin_count[p] < limit) pin_count[p] = pin_count[p] + 1'b1;
               else qualified[p] = 1'b1;
            end else begin
               if (pin_count[p] > 0) pin_count[p] = pin_count[p] - 1'b1;
               else qualified[p] = 1'b0;
            end
         end
         f.frame_byte0 = {START_BIT, address, sum_ch1[14:11]};
         f.frame_byte1 = sum_ch1[10:4];
         f.frame_byte2 = {qualified, sum_ch2[14:11]};
         f.frame_byte3 = sum_ch2[10:4];
         expected_frames.push_back(f);
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("frame %0d: %s expected 0x%02h, got 0x%02h",
                        frames_checked, field, want, got);
         end
      endfunction

      function void check_frame(frame_type got);
         frame_type want;
         if (expected_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("frame 0x%h arrived with no request outstanding", got);
            return;
         end
         want = expected_frames.pop_front();
         compare_field("byte0", want.frame_byte0, got.frame_byte0);
         compare_field("byte1", {1'b0, want.frame_byte1}, {1'b0, got.frame_byte1});
         compare_field("byte2", {1'b0, want.frame_byte2}, {1'b0, got.frame_byte2});
         compare_field("byte3", {1'b0, want.frame_byte3}, {1'b0, got.frame_byte3});
         frames_checked++;
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   sadf_req_if req_bus ();
   sadf_rsp_if rsp_bus ();

   frame_scoreboard      sb                 = new();
   int                   sender_idle_pct    = 0;
   int                   receiver_stall_pct = 0;
   int                   requests_sent      = 0;
   int                   settings_used      = 1;
   logic [PIN_COUNT-1:0] pin_trend          = '0;

   sensor_average_debounce_framer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_frame(frame_type'({rsp_bus.frame_byte0, rsp_bus.frame_byte1,
                                     rsp_bus.frame_byte2, rsp_bus.frame_byte3}));
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("no traffic for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10) return '0;
      if (roll < 25) return '1;
      // near full scale so the sums climb toward their top bits
      if (roll < 40)
         return SAMPLE_BITS'($urandom_range(2**SAMPLE_BITS - 1, 2**SAMPLE_BITS - 256));
      return SAMPLE_BITS'($urandom_range(2**SAMPLE_BITS - 1));
   endfunction

   task automatic send_request(input logic [SAMPLE_BITS-1:0] s1,
                               input logic [SAMPLE_BITS-1:0] s2,
                               input logic [PIN_COUNT-1:0] pins);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.sample_ch1 <= s1;
      req_bus.sample_ch2 <= s2;
      req_bus.pin0_level <= pins[0];
      req_bus.pin1_level <= pins[1];
      req_bus.pin2_level <= pins[2];
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      sb.note_request(s1, s2, pins);
      requests_sent++;
   endtask

   // Pins hold a level for long runs so the debouncers reach both rails;
   // the odd one-tick glitch exercises the integrator.
   task automatic send_random_request();
      logic [PIN_COUNT-1:0] pins;
      logic [1:0]           glitch_pin;
      for (int p = 0; p < PIN_COUNT; p++)
         if ($urandom_range(99) < 6) pin_trend[p] = ~pin_trend[p];
      pins = pin_trend;
      if ($urandom_range(99) < 4) begin
         glitch_pin       = 2'($urandom_range(PIN_COUNT - 1));
         pins[glitch_pin] = ~pins[glitch_pin];
      end
      send_request(pick_sample(), pick_sample(), pins);
   endtask

   task automatic program_registers(input logic [CSR_DATA_BITS-1:0] address_word,
                                    input logic [CSR_DATA_BITS-1:0] limit_word,
                                    input logic poke_unused);
      logic [CSR_INDEX_BITS-1:0] stray_index;
      logic [CSR_DATA_BITS-1:0]  stray_data;
      csr_we    <= 1'b1;
      csr_index <= CSR_MODULE_ADDRESS;
      csr_wdata <= address_word;
      @(posedge clock);
      sb.write_register(CSR_MODULE_ADDRESS, address_word);
      csr_index <= CSR_DEBOUNCE_LIMIT;
      csr_wdata <= limit_word;
      @(posedge clock);
      sb.write_register(CSR_DEBOUNCE_LIMIT, limit_word);
      if (poke_unused) begin
         // writes past the register list must change nothing
         stray_index = $urandom_range(1) ? CSR_UNUSED_INDEX : CSR_SPARE_INDEX;
         stray_data  = CSR_DATA_BITS'($urandom_range(15));
         csr_index <= stray_index;
         csr_wdata <= stray_data;
         @(posedge clock);
         sb.write_register(stray_index, stray_data);
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.expected_frames.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   initial begin
      logic [CSR_DATA_BITS-1:0] limit_word;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_MODULE_ADDRESS;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.sample_ch1 = '0;
      req_bus.sample_ch2 = '0;
      req_bus.pin0_level = 1'b0;
      req_bus.pin1_level = 1'b0;
      req_bus.pin2_level = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: full scale fills both sums, pins climb to the limit
      for (int i = 0; i < 11; i++) send_request('1, '1, '1);
      // channels apart, pins low: counters walk down, bits stay qualified
      for (int i = 0; i < 4; i++) send_request('1, '0, '0);
      drain();
      // address wider than three bits, zero limit, limit now below the counters
      program_registers(4'hF, '0, 1'b1);
      send_request('0, '1, 3'b000);
      for (int i = 0; i < 2; i++) begin
         send_request(12'hAAA, 12'h555, 3'b101);
         send_request(12'h555, 12'hAAA, 3'b010);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain();
         case (phase)
            0: limit_word = 4'd1;
            1: limit_word = 4'd15;
            2: limit_word = '0;
            default: limit_word = CSR_DATA_BITS'($urandom_range(15));
         endcase
         program_registers(CSR_DATA_BITS'($urandom_range(15)), limit_word, phase[0]);
         case (phase % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 79;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 79;
            end
            default: begin
               sender_idle_pct    = 16;
               receiver_stall_pct = 16;
            end
         endcase
         repeat (PHASE_REQUESTS) send_random_request();
      end
      drain();

      $display("Ran %0d sample ticks across %0d register settings and four flow-control mixes.",
               requests_sent, settings_used);
      $display("Frames checked: %0d, field mismatches: %0d.", sb.frames_checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_frames.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
